[hw/rtl/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg - shared types and helpers for the 3x3 matrix inverse unit
// Widths of the fixed-point datapath, lane side data and output saturation.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int EW            = 32;          // matrix entry width
    localparam int FRAC_BITS_DEF = 16;          // default fraction bits
    localparam int PW            = 64;          // product and cofactor width
    localparam int TW            = 96;          // |a| * |cofactor| width
    localparam int DET_W         = 99;          // determinant width
    localparam int QB            = 33;          // quotient bits kept
    localparam int DW            = DET_W + QB + 1;
    localparam int THR_W         = 63;
    localparam int NL            = 9;           // lanes, one per entry
    localparam int NC            = 3;           // first-row / first-column size

    localparam logic [THR_W-1:0] THR_RESET = 63'd4295;
    localparam logic [PW-1:0]    SMAX_MAG  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [PW-1:0]    SMIN_MAG  = 64'h0000_0000_8000_0000;
    localparam logic [EW-1:0]    SMAX      = 32'h7FFF_FFFF;
    localparam logic [EW-1:0]    SMIN      = 32'h8000_0000;

    typedef logic [NL-1:0][EW-1:0] mat_t;
    typedef logic [NL-1:0][PW-1:0] cof_t;
    typedef logic [NC-1:0][EW-1:0] row_t;

    typedef struct packed {
        logic                   sing;
        logic [NL-1:0]          neg;
        logic [NC-1:0][EW-1:0]  sv;
    } side_t;

    // sign and magnitude to a saturated two's complement entry
    function automatic logic [EW-1:0] sat32(input logic neg, input logic [PW-1:0] mag);
        logic [PW-1:0] n;
        n = PW'(0) - mag;
        if (neg)
        begin
            if (mag > SMIN_MAG)
                return SMIN;
            return n[EW-1:0];
        end
        if (mag > SMAX_MAG)
            return SMAX;
        return mag[EW-1:0];
    endfunction

endpackage

[hw/rtl/matrix3x3_inverse_unit.sv]
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit - 3x3 fixed-point matrix inverse by the adjugate
// Pipelined cofactors, determinant, bit-per-stage division and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one matrix a11..a33 per beat,
//   signed Q(31-F).F with F = FRAC_BITS. Output channel (out_valid /
//   out_ready) returns the inverse b11..b33 and the singular flag, one beat
//   per input beat, in order.
//   The pipeline has 2 cofactor stages, 3 determinant stages, 34 divider
//   stages (an overflow stage, then one quotient bit each) and the output
//   register. Throughput is one matrix per cycle while the receiver is ready.
//   Configuration channel (cfg_valid / cfg_ready) writes det_threshold; it is
//   always ready. Write it only with the pipeline empty.
//   A matrix whose |det| does not exceed det_threshold (Q.2F) is flagged
//   singular: the first column holds the rounded cofactors and the rest is
//   zero.
//   Reset empties every stage and loads the threshold with 4295.
//   When the receiver stalls, the output beat holds and stages behind it fill
//   their bubbles; in_ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [m3i_pkg::EW-1:0]      a11,
    input  logic [m3i_pkg::EW-1:0]      a12,
    input  logic [m3i_pkg::EW-1:0]      a13,
    input  logic [m3i_pkg::EW-1:0]      a21,
    input  logic [m3i_pkg::EW-1:0]      a22,
    input  logic [m3i_pkg::EW-1:0]      a23,
    input  logic [m3i_pkg::EW-1:0]      a31,
    input  logic [m3i_pkg::EW-1:0]      a32,
    input  logic [m3i_pkg::EW-1:0]      a33,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [m3i_pkg::EW-1:0]      b11,
    output logic [m3i_pkg::EW-1:0]      b12,
    output logic [m3i_pkg::EW-1:0]      b13,
    output logic [m3i_pkg::EW-1:0]      b21,
    output logic [m3i_pkg::EW-1:0]      b22,
    output logic [m3i_pkg::EW-1:0]      b23,
    output logic [m3i_pkg::EW-1:0]      b31,
    output logic [m3i_pkg::EW-1:0]      b32,
    output logic [m3i_pkg::EW-1:0]      b33,
    output logic                        singular,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [m3i_pkg::THR_W-1:0]   det_threshold
);
    import m3i_pkg::*;

    logic [THR_W-1:0]       thr_reg;

    mat_t                   a_in;
    logic                   cof_valid, cof_ready;
    cof_t                   cof;
    row_t                   a_row;

    logic                   det_valid, det_ready;
    logic [NL-1:0][DW-1:0]  num;
    logic [DW-1:0]          den;
    side_t                  det_side;

    logic                   div_valid, div_ready;
    logic [NL-1:0][QB-1:0]  quo;
    logic [NL-1:0]          quo_ovf;
    side_t                  div_side;

    logic                   out_valid_reg;
    logic                   out_en;
    mat_t                   b_reg, b_next;
    logic                   sing_reg;

    // threshold register: always ready, keep the low 63 bits
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= det_threshold;
    end

    assign a_in = {a33, a32, a31, a23, a22, a21, a13, a12, a11};

    m3i_cofactor u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a         (a_in),
        .out_valid (cof_valid),
        .out_ready (cof_ready),
        .c         (cof),
        .a_row     (a_row)
    );

    m3i_det #(
        .FRAC_BITS (FRAC_BITS)
    ) u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cof_valid),
        .in_ready  (cof_ready),
        .c         (cof),
        .a_row     (a_row),
        .thr       (thr_reg),
        .out_valid (det_valid),
        .out_ready (det_ready),
        .n         (num),
        .d         (den),
        .side      (det_side)
    );

    m3i_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (det_valid),
        .in_ready  (det_ready),
        .n         (num),
        .d         (den),
        .side_in   (det_side),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .q         (quo),
        .ovf       (quo_ovf),
        .side_out  (div_side)
    );

    // output register: advance when empty or when the current beat is taken
    assign out_en    = !out_valid_reg || out_ready;
    assign div_ready = out_en;

    always_comb
    begin
        logic [PW-1:0] mag;
        for (int l = 0; l < NL; l++)
        begin
            mag       = quo_ovf[l] ? {PW{1'b1}} : PW'(quo[l]);
            b_next[l] = sat32(div_side.neg[l], mag);
        end
        // singular: first column from the rounded cofactors, drop the rest
        if (div_side.sing)
        begin
            b_next = '0;
            for (int j = 0; j < NC; j++)
                b_next[3*j] = div_side.sv[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            b_reg    <= b_next;
            sing_reg <= div_side.sing;
        end
    end

    assign out_valid = out_valid_reg;
    assign singular  = sing_reg;
    assign b11 = b_reg[0];
    assign b12 = b_reg[1];
    assign b13 = b_reg[2];
    assign b21 = b_reg[3];
    assign b22 = b_reg[4];
    assign b23 = b_reg[5];
    assign b31 = b_reg[6];
    assign b32 = b_reg[7];
    assign b33 = b_reg[8];

endmodule

[hw/rtl/m3i_cofactor.sv]
// ----------------------------------------------------------------------------
// m3i_cofactor - adjugate front end
// Two stages: eighteen 32x32 products, then the nine cofactor differences.
// ----------------------------------------------------------------------------
module m3i_cofactor (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  m3i_pkg::mat_t   a,
    output logic            out_valid,
    input  logic            out_ready,
    output m3i_pkg::cof_t   c,
    output m3i_pkg::row_t   a_row
);
    import m3i_pkg::*;

    // c[i] = a[IX]*a[IY] - a[IU]*a[IV]
    localparam int IX [NL] = '{4, 2, 1, 5, 8, 2, 3, 6, 0};
    localparam int IY [NL] = '{8, 7, 5, 6, 0, 3, 7, 1, 4};
    localparam int IU [NL] = '{5, 1, 2, 3, 2, 5, 6, 0, 3};
    localparam int IV [NL] = '{7, 8, 4, 8, 6, 0, 4, 7, 1};

    logic                   v1_reg, v2_reg;
    logic                   en1, en2;
    logic signed [PW-1:0]   pp_reg [NL];
    logic signed [PW-1:0]   pm_reg [NL];
    logic signed [PW-1:0]   pp_next [NL];
    logic signed [PW-1:0]   pm_next [NL];
    row_t                   ar1_reg, ar2_reg;
    cof_t                   c_reg, c_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            pp_next[i] = $signed(a[IX[i]]) * $signed(a[IY[i]]);
            pm_next[i] = $signed(a[IU[i]]) * $signed(a[IV[i]]);
            c_next[i]  = PW'(pp_reg[i] - pm_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < NL; i++)
            begin
                pp_reg[i] <= pp_next[i];
                pm_reg[i] <= pm_next[i];
            end
            for (int j = 0; j < NC; j++)
                ar1_reg[j] <= a[j];
        end
        if (en2)
        begin
            c_reg   <= c_next;
            ar2_reg <= ar1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign c         = c_reg;
    assign a_row     = ar2_reg;

endmodule

[hw/rtl/m3i_det.sv]
// ----------------------------------------------------------------------------
// m3i_det - determinant, singular test and divider operands
// Three stages: split first-row products, signed sum, magnitude and rounding.
// ----------------------------------------------------------------------------
module m3i_det #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  m3i_pkg::cof_t                   c,
    input  m3i_pkg::row_t                   a_row,
    input  logic [m3i_pkg::THR_W-1:0]       thr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [m3i_pkg::NL-1:0][m3i_pkg::DW-1:0] n,
    output logic [m3i_pkg::DW-1:0]          d,
    output m3i_pkg::side_t                  side
);
    import m3i_pkg::*;

    localparam logic [PW:0] HALF_LSB = (PW+1)'(1) << (FRAC_BITS - 1);

    logic               v1_reg, v2_reg, v3_reg;
    logic               en1, en2, en3;
    logic [PW-1:0]      pl_reg [NC];
    logic [PW-1:0]      ph_reg [NC];
    logic [NC-1:0]      s_reg;
    cof_t               c1_reg, c2_reg;
    logic [DET_W-1:0]   det_reg, det_next;
    logic [NL-1:0][DW-1:0] n_reg, n_next;
    logic [DW-1:0]      d_reg, d_next;
    side_t              side_reg, side_next;

    logic [PW-1:0]      pl_next [NC];
    logic [PW-1:0]      ph_next [NC];
    logic [NC-1:0]      s_next;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: |a| times both halves of |cofactor|
    always_comb
    begin
        logic [EW-1:0] ma;
        logic [PW-1:0] mc;
        for (int i = 0; i < NC; i++)
        begin
            ma = a_row[i][EW-1] ? (EW'(0) - a_row[i]) : a_row[i];
            mc = c[3*i][PW-1] ? (PW'(0) - c[3*i]) : c[3*i];
            pl_next[i] = PW'(ma) * PW'(mc[31:0]);
            ph_next[i] = PW'(ma) * PW'(mc[63:32]);
            s_next[i]  = a_row[i][EW-1] ^ c[3*i][PW-1];
        end
    end

    // stage 2: signed sum along the first row
    always_comb
    begin
        logic [TW-1:0]    t;
        logic [DET_W-1:0] term;
        det_next = '0;
        for (int i = 0; i < NC; i++)
        begin
            t    = (TW'(ph_reg[i]) << 32) + TW'(pl_reg[i]);
            term = s_reg[i] ? (DET_W'(0) - DET_W'(t)) : DET_W'(t);
            det_next = det_next + term;
        end
    end

    // stage 3: |det|, threshold, numerators with the rounding half
    always_comb
    begin
        logic             dneg;
        logic [DET_W-1:0] dmag;
        logic [DET_W-1:0] thr_sh;
        logic [PW-1:0]    mc;
        logic [PW:0]      rs;
        dneg   = det_reg[DET_W-1];
        dmag   = dneg ? (DET_W'(0) - det_reg) : det_reg;
        thr_sh = DET_W'(thr) << FRAC_BITS;
        d_next = DW'(dmag);
        side_next.sing = !(dmag > thr_sh);
        for (int i = 0; i < NL; i++)
        begin
            mc = c2_reg[i][PW-1] ? (PW'(0) - c2_reg[i]) : c2_reg[i];
            n_next[i] = (DW'(mc) << (2 * FRAC_BITS)) + DW'(dmag >> 1);
            side_next.neg[i] = c2_reg[i][PW-1] ^ dneg;
        end
        for (int j = 0; j < NC; j++)
        begin
            mc = c2_reg[3*j][PW-1] ? (PW'(0) - c2_reg[3*j]) : c2_reg[3*j];
            rs = ((PW+1)'(mc) + HALF_LSB) >> FRAC_BITS;
            side_next.sv[j] = sat32(c2_reg[3*j][PW-1], rs[PW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < NC; i++)
            begin
                pl_reg[i] <= pl_next[i];
                ph_reg[i] <= ph_next[i];
            end
            s_reg  <= s_next;
            c1_reg <= c;
        end
        if (en2)
        begin
            det_reg <= det_next;
            c2_reg  <= c1_reg;
        end
        if (en3)
        begin
            n_reg    <= n_next;
            d_reg    <= d_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v3_reg;
    assign n         = n_reg;
    assign d         = d_reg;
    assign side      = side_reg;

endmodule

[hw/rtl/m3i_divider.sv]
// ----------------------------------------------------------------------------
// m3i_divider - nine-lane restoring divider, one quotient bit per stage
// A leading stage flags quotients of 2^QB or more; the rest develop the bits.
// ----------------------------------------------------------------------------
module m3i_divider (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [m3i_pkg::NL-1:0][m3i_pkg::DW-1:0] n,
    input  logic [m3i_pkg::DW-1:0]                  d,
    input  m3i_pkg::side_t                          side_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [m3i_pkg::NL-1:0][m3i_pkg::QB-1:0] q,
    output logic [m3i_pkg::NL-1:0]                  ovf,
    output m3i_pkg::side_t                          side_out
);
    import m3i_pkg::*;

    localparam int NS = QB + 1;

    logic [NS-1:0]  v_reg;
    logic [NS:0]    en;
    logic [DW-1:0]  rem_reg  [NS][NL];
    logic [DW-1:0]  rem_next [NS][NL];
    logic [QB-1:0]  q_reg    [NS][NL];
    logic [QB-1:0]  q_next   [NS][NL];
    logic [NL-1:0]  ovf_reg  [NS];
    logic [NL-1:0]  ovf_next [NS];
    logic [DW-1:0]  d_reg    [NS];
    logic [DW-1:0]  d_next   [NS];
    side_t          side_reg [NS];
    side_t          side_next[NS];

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
            en[s] = !v_reg[s] || en[s+1];
    end
    assign in_ready = en[0];

    always_comb
    begin
        logic [DW-1:0] dsh;
        dsh          = d << QB;
        d_next[0]    = d;
        side_next[0] = side_in;
        for (int l = 0; l < NL; l++)
        begin
            ovf_next[0][l] = (n[l] >= dsh);
            rem_next[0][l] = n[l];
            q_next[0][l]   = '0;
        end
        for (int s = 1; s < NS; s++)
        begin
            dsh          = d_reg[s-1] << (QB - s);
            d_next[s]    = d_reg[s-1];
            side_next[s] = side_reg[s-1];
            ovf_next[s]  = ovf_reg[s-1];
            for (int l = 0; l < NL; l++)
            begin
                rem_next[s][l] = rem_reg[s-1][l];
                q_next[s][l]   = q_reg[s-1][l];
                if (rem_reg[s-1][l] >= dsh)
                begin
                    rem_next[s][l]        = rem_reg[s-1][l] - dsh;
                    q_next[s][l][QB - s]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                if (en[s])
                    v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            if (en[s])
            begin
                d_reg[s]    <= d_next[s];
                side_reg[s] <= side_next[s];
                ovf_reg[s]  <= ovf_next[s];
                for (int l = 0; l < NL; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
            q[l] = q_reg[NS-1][l];
    end
    assign ovf       = ovf_reg[NS-1];
    assign side_out  = side_reg[NS-1];
    assign out_valid = v_reg[NS-1];

endmodule

[hw/rtl/m3i_checker.sv]
// ----------------------------------------------------------------------------
// m3i_checker - port-level checks for the matrix inverse unit
// Output hold under stall, singular result shape and back-pressure origin.
// ----------------------------------------------------------------------------
module m3i_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] b11,
    input logic [31:0] b12,
    input logic [31:0] b13,
    input logic [31:0] b22,
    input logic [31:0] b23,
    input logic [31:0] b32,
    input logic [31:0] b33,
    input logic        singular
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(b11) && $stable(b22) && $stable(singular))
        else $error("output payload changed while stalled");

    a_sing_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> (b12 == 32'd0) && (b13 == 32'd0) && (b22 == 32'd0)
            && (b23 == 32'd0) && (b32 == 32'd0) && (b33 == 32'd0))
        else $error("singular result with non-zero off-column entries");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind matrix3x3_inverse_unit m3i_checker u_m3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .b11       (b11),
    .b12       (b12),
    .b13       (b13),
    .b22       (b22),
    .b23       (b23),
    .b32       (b32),
    .b33       (b33),
    .singular  (singular)
);
